@@ hdl/rmf_pkg.sv @@
// rmf_pkg: shared types and constants of the rgb median filter
// no dependencies; used by the interfaces, the sort chain and the top level
`default_nettype none

package rmf_pkg;

    localparam int PIX_W      = 8;
    localparam int OUT_COL_W  = 10;
    localparam int OUT_ROW_W  = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int RAD_W      = 2;
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RST = 2'd1;
    localparam logic [WID_W-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [HGT_W-1:0] HEIGHT_RST = 13'd768;

    localparam logic FUNC_DRAIN = 1'b1;

    typedef struct packed {
        logic clear;
        logic insert;
        logic pick;
    } chain_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/rmf_if.sv @@
// rmf_if: valid/ready channel interfaces for pixels, results and register writes
// depends on rmf_pkg for field widths
`default_nettype none

interface rmf_in_if;
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [rmf_pkg::PIX_W-1:0] in_red;
    logic [rmf_pkg::PIX_W-1:0] in_green;
    logic [rmf_pkg::PIX_W-1:0] in_blue;
    modport source (output valid, func, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, func, in_red, in_green, in_blue, output ready);
endinterface

interface rmf_out_if;
    logic                         valid;
    logic                         ready;
    logic [rmf_pkg::PIX_W-1:0]     out_red;
    logic [rmf_pkg::PIX_W-1:0]     out_green;
    logic [rmf_pkg::PIX_W-1:0]     out_blue;
    logic [rmf_pkg::OUT_COL_W-1:0] out_col;
    logic [rmf_pkg::OUT_ROW_W-1:0] out_row;
    logic                         frame_end;
    modport source (output valid, out_red, out_green, out_blue, out_col, out_row, frame_end,
                    input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_col, out_row, frame_end,
                    output ready);
endinterface

interface rmf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rmf_pkg::CFG_IDX_W-1:0]  index;
    logic [rmf_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/rgb_median_filter_unit.sv @@
// rgb_median_filter_unit: per-channel median over a border-clipped square window
// depends on rmf_pkg, rmf_if, rmf_ram and rmf_sort_chain
//
// channels: in_ch takes raster-order pixels (func 0) or drain ticks (func 1);
// out_ch gives filtered pixels with their column, row and a frame end flag;
// cfg writes window_radius (index 0), image_width (1) and image_height (2);
// the user must write only while the block is idle; the block does not enforce it.
// a result for a pixel comes out once r*W + r later pixels have arrived;
// drain ticks after the frame flush the rest. one transaction is worked at a time:
// one causing no result is done in idle; one causing a result runs bounds, offsets,
// start, read, settle, pick and out. read takes the window values (up to 49 at
// radius 3) one per cycle from the line store's single read port into the sort chain.
// the output register holds a result while the receiver stalls; the next
// transaction is still taken, and its result waits until the register frees.
// reset clears counters, registers to radius 1, width 1024, height 768.
// the line store has no reset and needs no clearing pass.
`default_nettype none

module rgb_median_filter_unit #(
    parameter int MAX_RADIUS = 3,
    parameter int MAX_WIDTH  = 1024
) (
    input wire logic   clk,
    input wire logic   rst_n,
    rmf_in_if.sink     in_ch,
    rmf_out_if.source  out_ch,
    rmf_cfg_if.sink    cfg
);

    localparam int D   = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
    localparam int AW  = $clog2(D);
    localparam int PW  = $clog2(D + 1);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_RADIUS + 1);
    localparam int RRW = rmf_pkg::OUT_ROW_W;
    localparam int SW  = AW + 3;
    localparam int WIN = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int NW  = $clog2(WIN + 1);
    localparam int IW  = $clog2(WIN);
    localparam int KW  = $clog2(2 * MAX_RADIUS + 2);
    localparam int PXW = 3 * rmf_pkg::PIX_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_BOUNDS = 8'b0000_0010,
        S_OFFS   = 8'b0000_0100,
        S_START  = 8'b0000_1000,
        S_READ   = 8'b0001_0000,
        S_SETTLE = 8'b0010_0000,
        S_PICK   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [rmf_pkg::RAD_W-1:0] radius_reg;
    logic [rmf_pkg::WID_W-1:0] width_reg;
    logic [rmf_pkg::HGT_W-1:0] height_reg;
    logic [RW-1:0]             r_eff;
    logic [WW-1:0]             w_eff;
    logic [rmf_pkg::HGT_W-1:0] h_eff;
    logic [PW-1:0]             lag;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= rmf_pkg::RADIUS_RST;
            width_reg  <= rmf_pkg::WIDTH_RST;
            height_reg <= rmf_pkg::HEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                rmf_pkg::REG_RADIUS: radius_reg <= cfg.data[rmf_pkg::RAD_W-1:0];
                rmf_pkg::REG_WIDTH:  width_reg  <= cfg.data[rmf_pkg::WID_W-1:0];
                rmf_pkg::REG_HEIGHT: height_reg <= cfg.data[rmf_pkg::HGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        r_eff = (32'(radius_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_reg);
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        if (height_reg == '0)
            h_eff = rmf_pkg::HGT_W'(1);
        else if (32'(height_reg) > rmf_pkg::MAX_HEIGHT)
            h_eff = rmf_pkg::HGT_W'(rmf_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
        lag = PW'(r_eff) * PW'(w_eff) + PW'(r_eff);
    end

    // stream position and store bookkeeping
    logic [CW-1:0]  in_col_reg, emit_col_reg;
    logic [RRW-1:0] in_row_reg, emit_row_reg;
    logic [AW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  pending_reg;

    // job snapshot
    logic [CW-1:0]  job_col_reg;
    logic [RRW-1:0] job_row_reg;
    logic [AW-1:0]  job_base_reg;
    logic           job_fe_reg;

    logic in_acc, is_pix, emit_now;
    logic [PW-1:0]  pend_inc, pend_after;
    logic [AW-1:0]  wr_inc, wr_after;
    logic signed [SW-1:0] base_s;
    logic [AW-1:0]  base_w;
    logic [CW-1:0]  in_col_adv, emit_col_adv;
    logic [RRW-1:0] in_row_adv, emit_row_adv;
    logic           fe_now;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign is_pix      = (in_ch.func != rmf_pkg::FUNC_DRAIN);

    always_comb
    begin
        pend_inc = (32'(pending_reg) < D) ? pending_reg + PW'(1) : pending_reg;
        wr_inc   = (32'(wr_ptr_reg) == D - 1) ? '0 : wr_ptr_reg + AW'(1);
        pend_after = is_pix ? pend_inc : pending_reg;
        wr_after   = is_pix ? wr_inc : wr_ptr_reg;
        emit_now = is_pix ? (pend_inc > lag)
                          : (pending_reg != '0 && in_col_reg == '0 && in_row_reg == '0);
        base_s = SW'(wr_after) - SW'(pend_after);
        if (base_s < 0)
            base_s = base_s + SW'(D);
        base_w = AW'(base_s);

        // raster advance, clipped to the current frame
        if (32'(in_col_reg) + 1 >= 32'(w_eff))
        begin
            in_col_adv = '0;
            in_row_adv = (32'(in_row_reg) + 1 >= 32'(h_eff)) ? '0 : in_row_reg + RRW'(1);
        end
        else
        begin
            in_col_adv = in_col_reg + CW'(1);
            in_row_adv = in_row_reg;
        end
        if (32'(emit_col_reg) + 1 >= 32'(w_eff))
        begin
            emit_col_adv = '0;
            emit_row_adv = (32'(emit_row_reg) + 1 >= 32'(h_eff)) ? '0
                                                                 : emit_row_reg + RRW'(1);
        end
        else
        begin
            emit_col_adv = emit_col_reg + CW'(1);
            emit_row_adv = emit_row_reg;
        end
        fe_now = (32'(emit_row_reg) == 32'(h_eff) - 1) && (32'(emit_col_reg) == 32'(w_eff) - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            emit_col_reg <= '0;
            emit_row_reg <= '0;
            wr_ptr_reg   <= '0;
            pending_reg  <= '0;
        end
        else if (in_acc)
        begin
            wr_ptr_reg <= wr_after;
            if (is_pix)
            begin
                in_col_reg <= in_col_adv;
                in_row_reg <= in_row_adv;
            end
            if (emit_now)
            begin
                pending_reg  <= pend_after - PW'(1);
                emit_col_reg <= emit_col_adv;
                emit_row_reg <= emit_row_adv;
            end
            else
            begin
                pending_reg <= pend_after;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && emit_now)
        begin
            job_col_reg  <= emit_col_reg;
            job_row_reg  <= emit_row_reg;
            job_base_reg <= base_w;
            job_fe_reg   <= fe_now;
        end
    end

    // window geometry
    logic signed [SW-1:0] rs, cs, rr, hs, ws;
    logic signed [SW-1:0] rlo, rhi, clo, chi;
    logic signed [SW-1:0] dy0_reg, dx0_reg, offs_reg;
    logic [KW-1:0]        nrows_reg, ncols_reg;
    logic                 empty_reg;
    logic [NW-1:0]        n_reg;
    logic signed [SW-1:0] start_s;
    logic [AW-1:0]        addr_reg, rowaddr_reg, addr_inc, row_next;
    logic [AW:0]          row_sum;
    logic [KW-1:0]        x_cnt_reg, y_cnt_reg;
    logic                 ins_reg;

    always_comb
    begin
        rs = SW'(job_row_reg);
        cs = SW'(job_col_reg);
        rr = SW'(r_eff);
        hs = SW'(h_eff);
        ws = SW'(w_eff);
        rlo = (rs - rr < 0) ? '0 : rs - rr;
        rhi = (rs + rr > hs - 1) ? hs - 1 : rs + rr;
        clo = (cs - rr < 0) ? '0 : cs - rr;
        chi = (cs + rr > ws - 1) ? ws - 1 : cs + rr;
        start_s = SW'(job_base_reg) + offs_reg;
        if (start_s < 0)
            start_s = start_s + SW'(D);
        addr_inc = (32'(addr_reg) == D - 1) ? '0 : addr_reg + AW'(1);
        row_sum  = (AW+1)'(rowaddr_reg) + (AW+1)'(w_eff);
        row_next = (32'(row_sum) >= D) ? AW'(32'(row_sum) - D) : AW'(row_sum);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_BOUNDS:
            begin
                dy0_reg   <= rlo - rs;
                dx0_reg   <= clo - cs;
                nrows_reg <= KW'(rhi - rlo + 1);
                ncols_reg <= KW'(chi - clo + 1);
                empty_reg <= (rhi < rlo) || (chi < clo);
            end
            S_OFFS:
            begin
                offs_reg <= dy0_reg * ws + dx0_reg;
                n_reg    <= empty_reg ? '0 : NW'(32'(nrows_reg) * 32'(ncols_reg));
            end
            S_START:
            begin
                addr_reg    <= AW'(start_s);
                rowaddr_reg <= AW'(start_s);
                x_cnt_reg   <= '0;
                y_cnt_reg   <= '0;
            end
            S_READ:
            begin
                if (x_cnt_reg == ncols_reg - KW'(1))
                begin
                    x_cnt_reg   <= '0;
                    y_cnt_reg   <= y_cnt_reg + KW'(1);
                    addr_reg    <= row_next;
                    rowaddr_reg <= row_next;
                end
                else
                begin
                    x_cnt_reg <= x_cnt_reg + KW'(1);
                    addr_reg  <= addr_inc;
                end
            end
            default: ;
        endcase
    end

    // line store
    logic [PXW-1:0] rdata;

    rmf_ram #(
        .WIDTH (PXW),
        .DEPTH (D)
    ) u_store (
        .clk   (clk),
        .we    (in_acc && is_pix),
        .waddr (wr_ptr_reg),
        .wdata ({in_ch.in_red, in_ch.in_green, in_ch.in_blue}),
        .re    (state_reg == S_READ),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    // sorting chain
    rmf_pkg::chain_ctrl_t                   ctrl;
    logic [2:0][rmf_pkg::PIX_W-1:0]         x_in, lo_val, hi_val;

    assign ctrl.clear  = (state_reg == S_START);
    assign ctrl.insert = ins_reg;
    assign ctrl.pick   = (state_reg == S_PICK);
    assign x_in[0] = rdata[PXW-1 -: rmf_pkg::PIX_W];
    assign x_in[1] = rdata[2*rmf_pkg::PIX_W-1 -: rmf_pkg::PIX_W];
    assign x_in[2] = rdata[rmf_pkg::PIX_W-1:0];

    rmf_sort_chain #(
        .DEPTH (WIN)
    ) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .x      (x_in),
        .lo_idx (IW'((n_reg - NW'(1)) >> 1)),
        .hi_idx (IW'(n_reg >> 1)),
        .lo_val (lo_val),
        .hi_val (hi_val)
    );

    // sequencer
    logic last_read;
    assign last_read = (x_cnt_reg == ncols_reg - KW'(1)) &&
                       (y_cnt_reg == nrows_reg - KW'(1));

    logic out_valid_reg, out_load;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_acc && emit_now) state_next = S_BOUNDS;
            S_BOUNDS: state_next = S_OFFS;
            S_OFFS:   state_next = S_START;
            S_START:  state_next = empty_reg ? S_PICK : S_READ;
            S_READ:   if (last_read) state_next = S_SETTLE;
            S_SETTLE: state_next = S_PICK;
            S_PICK:   state_next = S_OUT;
            S_OUT:    if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ins_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ins_reg   <= (state_reg == S_READ);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // output register
    logic [2:0][rmf_pkg::PIX_W-1:0] med_reg;
    logic [CW-1:0]                  oc_reg;
    logic [RRW-1:0]                 or_reg;
    logic                           ofe_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                // floor average of the two middle values, both equal for odd counts
                med_reg[ch] <= (n_reg == '0) ? '0 :
                    rmf_pkg::PIX_W'(({1'b0, lo_val[ch]} + {1'b0, hi_val[ch]}) >> 1);
            end
            oc_reg  <= job_col_reg;
            or_reg  <= job_row_reg;
            ofe_reg <= job_fe_reg;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_red   = med_reg[0];
    assign out_ch.out_green = med_reg[1];
    assign out_ch.out_blue  = med_reg[2];
    assign out_ch.out_col   = rmf_pkg::OUT_COL_W'(oc_reg);
    assign out_ch.out_row   = or_reg;
    assign out_ch.frame_end = ofe_reg;

    // checks
    a_emit_starts_job: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && emit_now |=> state_reg == S_BOUNDS)
        else $error("result-causing transaction did not start a window job");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("output became valid outside the output step");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pending_reg) <= D)
        else $error("pending count above store depth");

    a_read_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> y_cnt_reg < nrows_reg && x_cnt_reg < ncols_reg)
        else $error("window read beyond its rows or columns");

endmodule

`default_nettype wire

@@ hdl/rmf_ram.sv @@
// rmf_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module rmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 6151
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/rmf_sort_cell.sv @@
// rmf_sort_cell: one slot of an insertion sorting chain, holds one value
// depends on rmf_pkg for the chain control struct
`default_nettype none

module rmf_sort_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire rmf_pkg::chain_ctrl_t      ctrl,
    input  wire logic [rmf_pkg::PIX_W-1:0] x,
    input  wire logic [rmf_pkg::PIX_W-1:0] prev_val,
    input  wire logic                      prev_valid,
    input  wire logic                      prev_le,
    output      logic [rmf_pkg::PIX_W-1:0] val,
    output      logic                      valid,
    output      logic                      le
);

    logic [rmf_pkg::PIX_W-1:0] val_reg;
    logic [rmf_pkg::PIX_W-1:0] val_next;
    logic                      valid_reg;
    logic                      valid_next;

    assign le = valid_reg && (val_reg <= x);

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.insert && !le)
        begin
            // new value lands here when the left neighbor stays, else shift right
            if (prev_le)
            begin
                val_next   = x;
                valid_next = 1'b1;
            end
            else
            begin
                val_next   = prev_val;
                valid_next = prev_valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val   = val_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

@@ hdl/rmf_sort_chain.sv @@
// rmf_sort_chain: three rows of sort cells (red, green, blue) and the middle pick
// depends on rmf_pkg and rmf_sort_cell
`default_nettype none

module rmf_sort_chain #(
    parameter int DEPTH = 49
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire rmf_pkg::chain_ctrl_t                 ctrl,
    input  wire logic [2:0][rmf_pkg::PIX_W-1:0]       x,
    input  wire logic [$clog2(DEPTH)-1:0]             lo_idx,
    input  wire logic [$clog2(DEPTH)-1:0]             hi_idx,
    output      logic [2:0][rmf_pkg::PIX_W-1:0]       lo_val,
    output      logic [2:0][rmf_pkg::PIX_W-1:0]       hi_val
);

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_lane
        logic [rmf_pkg::PIX_W-1:0] val [DEPTH];
        logic                      vld [DEPTH];
        logic                      le  [DEPTH];
        logic [rmf_pkg::PIX_W-1:0] lo_reg;
        logic [rmf_pkg::PIX_W-1:0] hi_reg;

        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                rmf_sort_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .x          (x[ch]),
                    .prev_val   (x[ch]),
                    .prev_valid (1'b1),
                    .prev_le    (1'b1),
                    .val        (val[i]),
                    .valid      (vld[i]),
                    .le         (le[i])
                );
            end
            else
            begin : g_body
                rmf_sort_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .x          (x[ch]),
                    .prev_val   (val[i-1]),
                    .prev_valid (vld[i-1]),
                    .prev_le    (le[i-1]),
                    .val        (val[i]),
                    .valid      (vld[i]),
                    .le         (le[i])
                );
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.pick)
            begin
                lo_reg <= val[lo_idx];
                hi_reg <= val[hi_idx];
            end
        end

        assign lo_val[ch] = lo_reg;
        assign hi_val[ch] = hi_reg;
    end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// tb: self-checking bench for rgb_median_filter_unit, raster frames with drain flush
// depends on rmf_pkg, rmf_if and the rtl under hdl/
`timescale 1ns / 1ps

module tb;

    localparam int STORE_DEPTH = 2 * 3 * 1024 + 2 * 3 + 1;
    localparam int WIN_MAX     = 49;
    localparam int LIMIT       = 1_000_000;
    localparam int RAND_PIXELS = 400;
    localparam int SETTLE      = 120;
    localparam logic [rmf_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic FUNC_PIXEL = 1'b0;

    typedef struct packed {
        logic [rmf_pkg::PIX_W-1:0]     red;
        logic [rmf_pkg::PIX_W-1:0]     green;
        logic [rmf_pkg::PIX_W-1:0]     blue;
        logic [rmf_pkg::OUT_COL_W-1:0] col;
        logic [rmf_pkg::OUT_ROW_W-1:0] row;
        logic                          frame_end;
    } filt_px_t;

    typedef struct {
        logic       func;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        bit         typed;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #5 clk = ~clk;

    rmf_in_if  in_ch();
    rmf_out_if out_ch();
    rmf_cfg_if cfg();

    rgb_median_filter_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // filter state as seen from outside
    logic [23:0]               pix_mem [STORE_DEPTH];
    int                        in_c, in_r, em_c, em_r, wptr, pend_cnt;
    logic [rmf_pkg::RAD_W-1:0] radius_q;
    logic [rmf_pkg::WID_W-1:0] width_q;
    logic [rmf_pkg::HGT_W-1:0] height_q;

    filt_px_t median_q[$];
    int  fails = 0;
    int  n_checked = 0;
    int  n_pixels = 0;
    int  n_drains = 0;
    int  hold_cycles = 0;
    bit  calm = 1'b0;
    int  cycle_cnt = 0;

    function automatic int eff_width();
        if (width_q < 1) return 1;
        return (width_q > 1024) ? 1024 : int'(width_q);
    endfunction

    function automatic int eff_height();
        if (height_q < 1) return 1;
        return (height_q > rmf_pkg::MAX_HEIGHT) ? rmf_pkg::MAX_HEIGHT : int'(height_q);
    endfunction

    function automatic void raster_next(ref int c, ref int r, input int w, input int h);
        if (c + 1 >= w) begin
            c = 0;
            r = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            c = c + 1;
        end
    endfunction

    function automatic logic [7:0] middle_of(logic [7:0] v[WIN_MAX], int n);
        int i, j;
        logic [7:0] x;
        if (n <= 0) return 8'd0;
        for (i = 1; i < n; i++) begin
            x = v[i];
            j = i - 1;
            while (j >= 0 && v[j] > x) begin
                v[j + 1] = v[j];
                j--;
            end
            v[j + 1] = x;
        end
        if (n % 2 == 0) return 8'((int'(v[(n - 1) / 2]) + int'(v[n / 2])) >> 1);
        return v[n / 2];
    endfunction

    function automatic filt_px_t window_median();
        int w, h, r, rlo, rhi, clo, chi, y, x, a, n;
        logic [7:0] vr[WIN_MAX], vg[WIN_MAX], vb[WIN_MAX];
        logic [23:0] px;
        filt_px_t res;
        w = eff_width();
        h = eff_height();
        r = radius_q;
        rlo = (em_r - r < 0) ? 0 : em_r - r;
        rhi = (em_r + r > h - 1) ? h - 1 : em_r + r;
        clo = (em_c - r < 0) ? 0 : em_c - r;
        chi = (em_c + r > w - 1) ? w - 1 : em_c + r;
        n = 0;
        for (y = rlo; y <= rhi; y++) begin
            for (x = clo; x <= chi; x++) begin
                a = (wptr - pend_cnt + (y - em_r) * w + (x - em_c)) % STORE_DEPTH;
                if (a < 0) a += STORE_DEPTH;
                px = pix_mem[a];
                if (n < WIN_MAX) begin
                    vr[n] = px[23:16];
                    vg[n] = px[15:8];
                    vb[n] = px[7:0];
                    n++;
                end
            end
        end
        res.red       = middle_of(vr, n);
        res.green     = middle_of(vg, n);
        res.blue      = middle_of(vb, n);
        res.col       = em_c[rmf_pkg::OUT_COL_W-1:0];
        res.row       = em_r[rmf_pkg::OUT_ROW_W-1:0];
        res.frame_end = (em_r == h - 1 && em_c == w - 1);
        if (pend_cnt > 0) pend_cnt--;
        raster_next(em_c, em_r, w, h);
        return res;
    endfunction

    // returns 1 when the transaction produces a filtered pixel
    function automatic bit filter_step(input logic f, input logic [23:0] pix,
                                       output filt_px_t res);
        int w, h, lag;
        w = eff_width();
        h = eff_height();
        lag = int'(radius_q) * w + int'(radius_q);
        if (f == FUNC_PIXEL) begin
            pix_mem[wptr] = pix;
            wptr = (wptr + 1 >= STORE_DEPTH) ? 0 : wptr + 1;
            if (pend_cnt < STORE_DEPTH) pend_cnt++;
            raster_next(in_c, in_r, w, h);
            if (pend_cnt > lag) begin
                res = window_median();
                return 1'b1;
            end
            return 1'b0;
        end
        if (pend_cnt > 0 && in_c == 0 && in_r == 0) begin
            res = window_median();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_item(input logic f, input logic [7:0] r, g, b, input bit typed);
        filt_px_t res;
        while (!calm && $urandom_range(99) < 29) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.func     <= f;
        in_ch.in_red   <= r;
        in_ch.in_green <= g;
        in_ch.in_blue  <= b;
        do @(posedge clk); while (!in_ch.ready);
        if (f == rmf_pkg::FUNC_DRAIN) n_drains++;
        else n_pixels++;
        if (filter_step(f, {r, g, b}, res)) begin
            if (typed) begin
                res = '{red: r, green: g, blue: b, col: '0, row: '0, frame_end: 1'b1};
                if (f == rmf_pkg::FUNC_DRAIN) res = '0;
            end
            median_q.push_back(res);
        end
    endtask

    task automatic write_reg(input logic [rmf_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value[rmf_pkg::CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            rmf_pkg::REG_RADIUS: radius_q = value[rmf_pkg::RAD_W-1:0];
            rmf_pkg::REG_WIDTH:  width_q  = value[rmf_pkg::WID_W-1:0];
            rmf_pkg::REG_HEIGHT: height_q = value[rmf_pkg::HGT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int r, input int w, input int h);
        write_reg(rmf_pkg::REG_RADIUS, r);
        write_reg(rmf_pkg::REG_WIDTH, w);
        write_reg(rmf_pkg::REG_HEIGHT, h);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (median_q.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic play_frames(input int frames, input bit noisy);
        int i;
        logic [7:0] c[3];
        for (i = 0; i < frames * eff_width() * eff_height(); i++) begin
            if (noisy && $urandom_range(99) < 4)
                send_item(rmf_pkg::FUNC_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom),
                          1'b0);
            foreach (c[k])
                c[k] = ($urandom_range(9) == 0) ? {8{1'($urandom_range(1))}} : 8'($urandom);
            send_item(FUNC_PIXEL, c[0], c[1], c[2], 1'b0);
        end
        // flush, then one tick that should be ignored
        while (pend_cnt > 0)
            send_item(rmf_pkg::FUNC_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
        send_item(rmf_pkg::FUNC_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    endtask

    // receiver: checks each accepted transaction, then decides next ready
    initial begin
        filt_px_t want, got;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.out_red, out_ch.out_green, out_ch.out_blue,
                        out_ch.out_col, out_ch.out_row, out_ch.frame_end};
                n_checked++;
                if (median_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, actual %p", $time, got);
                end else begin
                    want = median_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(99) >= 29);
            end
        end
    end

    initial begin
        while (cycle_cnt < LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Verification failed");
        $finish;
    end

    // radius 0 on a 1x1 frame: every pixel comes straight back, drain gives nothing
    stim_row_t directed[] = '{
        '{FUNC_PIXEL,          8'd0,   8'd0,   8'd0,   1'b1},
        '{FUNC_PIXEL,          8'd255, 8'd255, 8'd255, 1'b1},
        '{FUNC_PIXEL,          8'd255, 8'd0,   8'd170, 1'b1},
        '{FUNC_PIXEL,          8'd1,   8'd128, 8'd254, 1'b1},
        '{rmf_pkg::FUNC_DRAIN, 8'd255, 8'd255, 8'd255, 1'b1},
        '{FUNC_PIXEL,          8'd85,  8'd170, 8'd15,  1'b1},
        '{rmf_pkg::FUNC_DRAIN, 8'd0,   8'd0,   8'd0,   1'b1},
        '{FUNC_PIXEL,          8'd127, 8'd64,  8'd32,  1'b0},
        '{FUNC_PIXEL,          8'd16,  8'd8,   8'd4,   1'b0},
        '{FUNC_PIXEL,          8'd2,   8'd240, 8'd99,  1'b0}
    };

    initial begin
        int p, nrand, nf, r_set, w_set, h_set;
        in_ch.valid    <= 1'b0;
        in_ch.func     <= FUNC_PIXEL;
        in_ch.in_red   <= '0;
        in_ch.in_green <= '0;
        in_ch.in_blue  <= '0;
        cfg.valid      <= 1'b0;
        cfg.index      <= rmf_pkg::REG_RADIUS;
        cfg.data       <= '0;
        foreach (pix_mem[k]) pix_mem[k] = '0;
        {in_c, in_r, em_c, em_r, wptr, pend_cnt} = '0;
        radius_q = rmf_pkg::RADIUS_RST;
        width_q  = rmf_pkg::WIDTH_RST;
        height_q = rmf_pkg::HEIGHT_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_SPARE, $urandom_range(8191));
        set_config(0, 1, 1);
        foreach (directed[k])
            send_item(directed[k].func, directed[k].red, directed[k].green,
                      directed[k].blue, directed[k].typed);
        settle();

        nrand = 0;
        p = 0;
        while (nrand < RAND_PIXELS) begin
            case (p)
                0: set_config(3, 0, 0);         // clamps to 1 x 1
                1: set_config(2, 7, 0);         // height clamps to 1
                2: set_config(3, 7, 7);
                default: begin
                    r_set = $urandom_range(3);
                    w_set = ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1);
                    h_set = ($urandom_range(9) == 0) ? 0 : $urandom_range(9, 1);
                    set_config(r_set, w_set, h_set);
                end
            endcase
            calm = (p == 3);
            if (p == 2) hold_cycles = 400;
            nf = (p < 2) ? 1 : $urandom_range(2, 1);
            nrand += nf * eff_width() * eff_height();
            play_frames(nf, p >= 2);
            settle();
            p++;
        end

        $display("ran %0d configurations: %0d pixels, %0d drain ticks, %0d results checked",
                 p + 1, n_pixels, n_drains, n_checked);
        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", fails);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ rgb_median_filter_unit.f @@
hdl/rmf_pkg.sv
hdl/rmf_if.sv
hdl/rmf_ram.sv
hdl/rmf_sort_cell.sv
hdl/rmf_sort_chain.sv
hdl/rgb_median_filter_unit.sv
bench/tb.sv
